// ===== design/fpp_pkg.sv =====
// Shared types, character codes and the piece letter decode for the FEN position parser.
package fpp_pkg;

    // Result kinds.
    localparam logic KIND_PLACEMENT = 1'b0;
    localparam logic KIND_SUMMARY   = 1'b1;

    // Field numbers within the FEN string.
    localparam logic [2:0] FIELD_BOARD    = 3'd0;
    localparam logic [2:0] FIELD_TURN     = 3'd1;
    localparam logic [2:0] FIELD_CASTLE   = 3'd2;
    localparam logic [2:0] FIELD_PASSANT  = 3'd3;
    localparam logic [2:0] FIELD_HALFMOVE = 3'd4;
    localparam logic [2:0] FIELD_FULLMOVE = 3'd5;
    localparam logic [2:0] FIELD_LAST     = 3'd7;

    // Board cursor constants.
    localparam logic [7:0] CURSOR_START = 8'd56;
    localparam logic [7:0] RANK_DROP    = 8'd16;

    // Characters with a meaning somewhere in the string.
    localparam logic [7:0] CHR_0     = 8'h30;
    localparam logic [7:0] CHR_1     = 8'h31;
    localparam logic [7:0] CHR_8     = 8'h38;
    localparam logic [7:0] CHR_9     = 8'h39;
    localparam logic [7:0] CHR_SLASH = 8'h2f;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_DASH  = 8'h2d;
    localparam logic [7:0] CHR_LOW_A = 8'h61;
    localparam logic [7:0] CHR_LOW_H = 8'h68;
    localparam logic [7:0] CHR_LOW_W = 8'h77;
    localparam logic [7:0] CHR_LOW_B = 8'h62;
    localparam logic [7:0] CHR_UP_K  = 8'h4b;
    localparam logic [7:0] CHR_UP_Q  = 8'h51;
    localparam logic [7:0] CHR_LOW_K = 8'h6b;
    localparam logic [7:0] CHR_LOW_Q = 8'h71;

    // Castling right bits.
    localparam logic [3:0] CASTLE_WK = 4'b0001;
    localparam logic [3:0] CASTLE_WQ = 4'b0010;
    localparam logic [3:0] CASTLE_BK = 4'b0100;
    localparam logic [3:0] CASTLE_BQ = 4'b1000;

    localparam int         NUM_PIECES  = 12;
    localparam logic [3:0] FIRST_BLACK = 4'd6;

    // White PNBRQK, then black pnbrqk; the index is the piece code.
    localparam logic [7:0] PIECE_LETTERS [NUM_PIECES] = '{
        8'h50, 8'h4e, 8'h42, 8'h52, 8'h51, 8'h4b,
        8'h70, 8'h6e, 8'h62, 8'h72, 8'h71, 8'h6b
    };

    typedef struct packed {
        logic       hit;
        logic [3:0] code;
    } fpp_piece_t;

    typedef struct packed {
        logic        kind;
        logic [5:0]  square;
        logic [3:0]  piece_code;
        logic        white_to_move;
        logic [3:0]  castle_rights;
        logic        passant_valid;
        logic [5:0]  passant_square;
        logic [15:0] halfmove_clock;
        logic [15:0] fullmove_number;
        logic [63:0] white_occupancy;
        logic [63:0] black_occupancy;
        logic        last_of_run;
    } fpp_result_t;

    function automatic fpp_piece_t piece_lookup(input logic [7:0] c);
        fpp_piece_t p;
        p.hit  = 1'b0;
        p.code = 4'd0;
        for (int i = 0; i < NUM_PIECES; i++)
        begin
            if (c == PIECE_LETTERS[i])
            begin
                p.hit  = 1'b1;
                p.code = 4'(i);
            end
        end
        return p;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHR_0) && (c <= CHR_9);
    endfunction

endpackage

// ===== design/fen_position_parser_core.sv =====
// FEN position parser: decodes a chess position string one character per beat.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  input   | in        | in_valid / in_ready  | text_byte, end_of_string
//  output  | out       | out_valid / out_ready| kind, square, piece_code, summary fields,
//          |           |                      | last_of_run
//
// Every character is decoded in the cycle it is accepted and its first result is in the
// output register in the cycle after, so one input beat per cycle is taken when out_ready
// stays high. A character that places a piece and also ends the string gives two beats;
// the summary waits in a second register and the input is held until it moves to the
// port. The input is also held while a beat sits unread on the port.
// Reset is asynchronous and active low; it empties both result registers.
module fen_position_parser_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        end_of_string,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [5:0]  square,
    output logic [3:0]  piece_code,
    output logic        white_to_move,
    output logic [3:0]  castle_rights,
    output logic        passant_valid,
    output logic [5:0]  passant_square,
    output logic [15:0] halfmove_clock,
    output logic [15:0] fullmove_number,
    output logic [63:0] white_occupancy,
    output logic [63:0] black_occupancy,
    output logic        last_of_run
);

    localparam int ProdWidth = COUNT_WIDTH + 4;
    localparam logic [ProdWidth-1:0] CountMax = {4'b0, {COUNT_WIDTH{1'b1}}};

    // Parser state.
    logic [7:0]             cursor_reg,   cursor_next;
    logic [2:0]             field_reg,    field_next;
    logic                   turn_reg,     turn_next;
    logic [3:0]             castle_reg,   castle_next;
    logic                   pflag_reg,    pflag_next;
    logic [5:0]             ptarget_reg,  ptarget_next;
    logic                   ppend_reg,    ppend_next;
    logic [2:0]             pfile_reg,    pfile_next;
    logic [COUNT_WIDTH-1:0] half_reg,     half_next;
    logic [COUNT_WIDTH-1:0] full_reg,     full_next;
    logic [63:0]            white_reg,    white_next;
    logic [63:0]            black_reg,    black_next;

    // Result registers: the one on the ports and a second one for a trailing summary.
    fpp_pkg::fpp_result_t   out_reg,      out_next;
    fpp_pkg::fpp_result_t   pend_reg,     pend_next;
    logic                   out_vld_reg,  out_vld_next;
    logic                   pend_vld_reg, pend_vld_next;

    // Decode of the current character.
    logic                   accept;
    logic                   consumed;
    logic                   place_hit;
    logic [3:0]             digit_val;
    logic [2:0]             field_upd;
    logic [7:0]             cursor_upd;
    logic                   turn_upd;
    logic [3:0]             castle_upd;
    logic                   pflag_upd;
    logic [5:0]             ptarget_upd;
    logic                   ppend_upd;
    logic [2:0]             pfile_upd;
    logic [COUNT_WIDTH-1:0] half_upd;
    logic [COUNT_WIDTH-1:0] full_upd;
    logic [63:0]            white_upd;
    logic [63:0]            black_upd;
    logic [63:0]            square_bit;
    logic [ProdWidth-1:0]   half_prod;
    logic [ProdWidth-1:0]   full_prod;
    fpp_pkg::fpp_piece_t    piece;
    fpp_pkg::fpp_result_t   place_res;
    fpp_pkg::fpp_result_t   summary_res;

    // A new character may enter once the second register is empty and the port
    // register is free or being drained in this cycle.
    assign in_ready = !pend_vld_reg && (!out_vld_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        piece      = fpp_pkg::piece_lookup(text_byte);
        digit_val  = 4'(text_byte - fpp_pkg::CHR_0);
        square_bit = 64'd1 << cursor_reg[5:0];

        consumed    = 1'b0;
        ppend_upd   = 1'b0;
        pflag_upd   = pflag_reg;
        ptarget_upd = ptarget_reg;
        pfile_upd   = pfile_reg;
        cursor_upd  = cursor_reg;
        field_upd   = field_reg;
        turn_upd    = turn_reg;
        castle_upd  = castle_reg;
        half_upd    = half_reg;
        full_upd    = full_reg;
        white_upd   = white_reg;
        black_upd   = black_reg;
        place_hit   = 1'b0;

        // Times ten plus the digit, as two shifted copies and an add.
        half_prod = ({2'b0, half_reg, 2'b0} << 1) + {3'b0, half_reg, 1'b0}
                    + ProdWidth'(digit_val);
        full_prod = ({2'b0, full_reg, 2'b0} << 1) + {3'b0, full_reg, 1'b0}
                    + ProdWidth'(digit_val);

        // The rank digit right after an en-passant file letter is taken here.
        if (ppend_reg && fpp_pkg::is_digit(text_byte))
        begin
            consumed = 1'b1;
            if ((text_byte >= fpp_pkg::CHR_1) && (text_byte <= fpp_pkg::CHR_8))
            begin
                pflag_upd   = 1'b1;
                ptarget_upd = {3'(text_byte - fpp_pkg::CHR_1), pfile_reg};
            end
        end

        if (!consumed)
        begin
            if (field_reg == fpp_pkg::FIELD_BOARD)
            begin
                if (fpp_pkg::is_digit(text_byte))
                begin
                    cursor_upd = cursor_reg + {4'b0, digit_val};
                end
                else if (text_byte == fpp_pkg::CHR_SLASH)
                begin
                    cursor_upd = cursor_reg - fpp_pkg::RANK_DROP;
                end
                else
                begin
                    // Letters off the board still move the cursor but place nothing.
                    if (piece.hit && (cursor_reg[7:6] == 2'b00))
                    begin
                        place_hit = 1'b1;
                        if (piece.code < fpp_pkg::FIRST_BLACK)
                        begin
                            white_upd = white_reg | square_bit;
                        end
                        else
                        begin
                            black_upd = black_reg | square_bit;
                        end
                    end
                    cursor_upd = cursor_reg + 8'd1;
                end
            end

            if ((text_byte == fpp_pkg::CHR_SPACE) && (field_reg != fpp_pkg::FIELD_LAST))
            begin
                field_upd = field_reg + 3'd1;
            end

            case (field_upd)
                fpp_pkg::FIELD_TURN:
                begin
                    if (text_byte == fpp_pkg::CHR_LOW_W)
                    begin
                        turn_upd = 1'b1;
                    end
                    else if (text_byte == fpp_pkg::CHR_LOW_B)
                    begin
                        turn_upd = 1'b0;
                    end
                end
                fpp_pkg::FIELD_CASTLE:
                begin
                    if (text_byte == fpp_pkg::CHR_UP_K)
                    begin
                        castle_upd = castle_reg | fpp_pkg::CASTLE_WK;
                    end
                    else if (text_byte == fpp_pkg::CHR_UP_Q)
                    begin
                        castle_upd = castle_reg | fpp_pkg::CASTLE_WQ;
                    end
                    else if (text_byte == fpp_pkg::CHR_LOW_K)
                    begin
                        castle_upd = castle_reg | fpp_pkg::CASTLE_BK;
                    end
                    else if (text_byte == fpp_pkg::CHR_LOW_Q)
                    begin
                        castle_upd = castle_reg | fpp_pkg::CASTLE_BQ;
                    end
                    else if (text_byte == fpp_pkg::CHR_DASH)
                    begin
                        castle_upd = 4'b0;
                    end
                end
                fpp_pkg::FIELD_PASSANT:
                begin
                    if (text_byte == fpp_pkg::CHR_DASH)
                    begin
                        pflag_upd = 1'b0;
                    end
                    else if ((text_byte >= fpp_pkg::CHR_LOW_A) &&
                             (text_byte <= fpp_pkg::CHR_LOW_H))
                    begin
                        ppend_upd = 1'b1;
                        pfile_upd = 3'(text_byte - fpp_pkg::CHR_LOW_A);
                    end
                end
                fpp_pkg::FIELD_HALFMOVE:
                begin
                    if (fpp_pkg::is_digit(text_byte))
                    begin
                        half_upd = (half_prod > CountMax) ? COUNT_WIDTH'(CountMax)
                                                          : half_prod[COUNT_WIDTH-1:0];
                    end
                end
                fpp_pkg::FIELD_FULLMOVE:
                begin
                    if (fpp_pkg::is_digit(text_byte))
                    begin
                        full_upd = (full_prod > CountMax) ? COUNT_WIDTH'(CountMax)
                                                          : full_prod[COUNT_WIDTH-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end

        place_res             = '0;
        place_res.kind        = fpp_pkg::KIND_PLACEMENT;
        place_res.square      = cursor_reg[5:0];
        place_res.piece_code  = piece.code;
        place_res.last_of_run = !end_of_string;

        // The summary reflects the state after this character has been applied.
        summary_res                 = '0;
        summary_res.kind            = fpp_pkg::KIND_SUMMARY;
        summary_res.white_to_move   = turn_upd;
        summary_res.castle_rights   = castle_upd;
        summary_res.passant_valid   = pflag_upd;
        summary_res.passant_square  = pflag_upd ? ptarget_upd : 6'd0;
        summary_res.halfmove_clock  = 16'(half_upd);
        summary_res.fullmove_number = 16'(full_upd);
        summary_res.white_occupancy = white_upd;
        summary_res.black_occupancy = black_upd;
        summary_res.last_of_run     = 1'b1;
    end

    // State advance; the end of a string returns everything to the start values.
    always_comb
    begin
        cursor_next  = cursor_reg;
        field_next   = field_reg;
        turn_next    = turn_reg;
        castle_next  = castle_reg;
        pflag_next   = pflag_reg;
        ptarget_next = ptarget_reg;
        ppend_next   = ppend_reg;
        pfile_next   = pfile_reg;
        half_next    = half_reg;
        full_next    = full_reg;
        white_next   = white_reg;
        black_next   = black_reg;
        if (accept)
        begin
            if (end_of_string)
            begin
                cursor_next  = fpp_pkg::CURSOR_START;
                field_next   = fpp_pkg::FIELD_BOARD;
                turn_next    = 1'b1;
                castle_next  = 4'b0;
                pflag_next   = 1'b0;
                ptarget_next = 6'd0;
                ppend_next   = 1'b0;
                pfile_next   = 3'd0;
                half_next    = '0;
                full_next    = '0;
                white_next   = 64'd0;
                black_next   = 64'd0;
            end
            else
            begin
                cursor_next  = cursor_upd;
                field_next   = field_upd;
                turn_next    = turn_upd;
                castle_next  = castle_upd;
                pflag_next   = pflag_upd;
                ptarget_next = ptarget_upd;
                ppend_next   = ppend_upd;
                pfile_next   = pfile_upd;
                half_next    = half_upd;
                full_next    = full_upd;
                white_next   = white_upd;
                black_next   = black_upd;
            end
        end
    end

    // Result registers. An accepted character always finds the port register free
    // or draining, so its results simply replace it.
    always_comb
    begin
        out_next      = out_reg;
        pend_next     = pend_reg;
        out_vld_next  = out_vld_reg;
        pend_vld_next = pend_vld_reg;
        if (accept)
        begin
            if (place_hit)
            begin
                out_next      = place_res;
                out_vld_next  = 1'b1;
                pend_next     = summary_res;
                pend_vld_next = end_of_string;
            end
            else if (end_of_string)
            begin
                out_next     = summary_res;
                out_vld_next = 1'b1;
            end
            else
            begin
                out_vld_next = 1'b0;
            end
        end
        else if (out_vld_reg && out_ready)
        begin
            out_next      = pend_reg;
            out_vld_next  = pend_vld_reg;
            pend_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg   <= fpp_pkg::CURSOR_START;
            field_reg    <= fpp_pkg::FIELD_BOARD;
            turn_reg     <= 1'b1;
            castle_reg   <= 4'b0;
            pflag_reg    <= 1'b0;
            ptarget_reg  <= 6'd0;
            ppend_reg    <= 1'b0;
            pfile_reg    <= 3'd0;
            half_reg     <= '0;
            full_reg     <= '0;
            white_reg    <= 64'd0;
            black_reg    <= 64'd0;
            out_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            cursor_reg   <= cursor_next;
            field_reg    <= field_next;
            turn_reg     <= turn_next;
            castle_reg   <= castle_next;
            pflag_reg    <= pflag_next;
            ptarget_reg  <= ptarget_next;
            ppend_reg    <= ppend_next;
            pfile_reg    <= pfile_next;
            half_reg     <= half_next;
            full_reg     <= full_next;
            white_reg    <= white_next;
            black_reg    <= black_next;
            out_vld_reg  <= out_vld_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    // Result payloads carry no reset; the valid flags qualify them.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign out_valid       = out_vld_reg;
    assign kind            = out_reg.kind;
    assign square          = out_reg.square;
    assign piece_code      = out_reg.piece_code;
    assign white_to_move   = out_reg.white_to_move;
    assign castle_rights   = out_reg.castle_rights;
    assign passant_valid   = out_reg.passant_valid;
    assign passant_square  = out_reg.passant_square;
    assign halfmove_clock  = out_reg.halfmove_clock;
    assign fullmove_number = out_reg.fullmove_number;
    assign white_occupancy = out_reg.white_occupancy;
    assign black_occupancy = out_reg.black_occupancy;
    assign last_of_run     = out_reg.last_of_run;

endmodule

// ===== design/fpp_checker.sv =====
// Port-level assertions for the FEN position parser and the bind that attaches them.
module fpp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        end_of_string,
    input logic        out_valid,
    input logic        out_ready,
    input logic        kind,
    input logic [3:0]  piece_code,
    input logic [3:0]  castle_rights,
    input logic        passant_valid,
    input logic [63:0] white_occupancy,
    input logic [63:0] black_occupancy,
    input logic        last_of_run
);

    // A stalled output beat keeps its kind, piece code and last_of_run flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(piece_code)
                                    && $stable(last_of_run))
    else $error("output beat changed while stalled");

    // A summary is always the final beat of its character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == fpp_pkg::KIND_SUMMARY) |-> last_of_run)
    else $error("summary beat without last_of_run");

    // Placement beats carry a real piece code and no summary contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == fpp_pkg::KIND_PLACEMENT) |->
            (piece_code <= 4'd11) && (castle_rights == 4'd0) && !passant_valid
            && (white_occupancy == 64'd0) && (black_occupancy == 64'd0))
    else $error("malformed placement beat");

    // The end of a string shows up at once, either as the summary or ahead of it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_string |=>
            out_valid && ((kind == fpp_pkg::KIND_SUMMARY) || !last_of_run))
    else $error("end of string produced no pending summary");

endmodule

bind fen_position_parser_core fpp_checker u_fpp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .end_of_string   (end_of_string),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .piece_code      (piece_code),
    .castle_rights   (castle_rights),
    .passant_valid   (passant_valid),
    .white_occupancy (white_occupancy),
    .black_occupancy (black_occupancy),
    .last_of_run     (last_of_run)
);
